/* rtl/tcce_pkg.sv */
// ----------------------------------------------------------------------------
// TCP client connection engine - shared definitions
// Slot geometry, connection state codes, flag bits, slot record and result
// word layout, and the port-to-slot reduction tables.
// ----------------------------------------------------------------------------
package tcce_pkg;

   localparam int CONN_SLOTS = 16;
   localparam int SLOT_W     = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;

   // opcodes
   localparam logic [1:0] OP_RECV = 2'd0;
   localparam logic [1:0] OP_OPEN = 2'd1;
   localparam logic [1:0] OP_SEND = 2'd2;

   // connection states
   localparam logic [3:0] ST_CLOSED      = 4'd0;
   localparam logic [3:0] ST_SYN_SENT    = 4'd2;
   localparam logic [3:0] ST_ESTABLISHED = 4'd4;
   localparam logic [3:0] ST_CLOSE_WAIT  = 4'd7;

   // flag bits
   localparam logic [8:0] F_FIN = 9'h001;
   localparam logic [8:0] F_SYN = 9'h002;
   localparam logic [8:0] F_PSH = 9'h008;
   localparam logic [8:0] F_ACK = 9'h010;

   // header lengths in 32-bit words
   localparam logic [2:0] HDR_NONE  = 3'd0;
   localparam logic [2:0] HDR_PLAIN = 3'd5;
   localparam logic [2:0] HDR_MSS   = 3'd6;

   localparam logic [15:0] PORT_START = 16'd51673;

   typedef struct packed {
      logic [3:0]  state;
      logic [31:0] peer_address;
      logic [15:0] own_port;
      logic [15:0] peer_port;
      logic [31:0] own_seq;
      logic [31:0] peer_seq;
   } slot_type;

   localparam int SLOT_BITS = $bits(slot_type);

   typedef struct packed {
      logic        last_result;
      logic [31:0] dest_address;
      logic [15:0] from_port;
      logic [15:0] to_port;
      logic [31:0] seq_out;
      logic [31:0] ack_out;
      logic [2:0]  header_words;
      logic [8:0]  flags_out;
      logic [3:0]  conn_state;
      logic        deliver;
      logic [5:0]  payload_offset;
      logic [15:0] payload_length;
   } rsp_type;

   // port mod CONN_SLOTS = (hi*256 mod N + lo mod N), folded once
   typedef logic [SLOT_W:0] slot_sum_type;
   typedef slot_sum_type [255:0] slot_table_type;

   function automatic slot_table_type build_slot_table(bit high_byte);
      slot_table_type t;
      int             v;
      for (int i = 0; i < 256; i++) begin
         v    = high_byte ? (i * 256) % CONN_SLOTS : i % CONN_SLOTS;
         t[i] = slot_sum_type'(v);
      end
      return t;
   endfunction

   localparam slot_table_type SLOT_HI = build_slot_table(1'b1);
   localparam slot_table_type SLOT_LO = build_slot_table(1'b0);

   function automatic logic [SLOT_W-1:0] slot_of(logic [15:0] port);
      slot_sum_type sum;
      sum = SLOT_HI[port[15:8]] + SLOT_LO[port[7:0]];
      if (sum >= slot_sum_type'(CONN_SLOTS)) begin
         sum = sum - slot_sum_type'(CONN_SLOTS);
      end
      return sum[SLOT_W-1:0];
   endfunction

endpackage

/* rtl/tcce_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tcp_client_connection_engine.sv */
// ----------------------------------------------------------------------------
// TCP client connection engine
// Per-slot TCP client state machine: open, receive and send requests in,
// outgoing header descriptors out.
// ----------------------------------------------------------------------------
// A slot record is read from the slot RAM as its item is accepted, then
// updated, written back and registered as result words. A new request can
// be taken every cycle unless the result queue still holds words not yet
// taken. Each item yields one result word, or two when a segment received on
// an established connection carries both PSH and FIN; the result port moves
// one word per cycle while rsp_tready is high. Slot state comes out of reset
// CLOSED through a valid bit per slot, so no clearing pass is needed.
module tcp_client_connection_engine (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // local_port[15:0], remote_ip[47:16], remote_port[63:48], seq_in[95:64],
   // ack_in[127:96], flags_in[136:128], data_offset[140:137],
   // segment_length[156:141], zero pad[159:157]
   input  logic [159:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // dest_address[31:0], from_port[47:32], to_port[63:48], seq_out[95:64],
   // ack_out[127:96], header_words[130:128], flags_out[139:131],
   // conn_state[143:140], deliver[144], payload_offset[150:145],
   // payload_length[166:151], zero pad[167]
   output logic [167:0] rsp_tdata,
   output logic         rsp_tlast
);

   typedef struct packed {
      logic [1:0]                  op;
      logic [15:0]                 port;
      logic [tcce_pkg::SLOT_W-1:0] slot;
      logic [31:0]                 rip;
      logic [15:0]                 rport;
      logic [31:0]                 seq;
      logic [4:0]                  flags;
      logic [3:0]                  doff;
      logic [15:0]                 slen;
   } stg_type;

   // ---------------------------------------------------------------- registers
   logic                           stg_valid_ff, stg_valid_in;
   stg_type                        stg_ff, stg_in;
   logic [15:0]                    port_ff, port_in;
   logic [tcce_pkg::CONN_SLOTS-1:0] valid_ff, valid_in;
   logic                           byp_hit_ff, byp_hit_in;
   tcce_pkg::slot_type             byp_data_ff, byp_data_in;
   tcce_pkg::rsp_type              out0_ff, out0_in, out1_ff, out1_in;
   logic [1:0]                     out_cnt_ff, out_cnt_in;

   // ---------------------------------------------------------------- signals
   logic                           acc, adv, pop;
   logic [1:0]                     req_op;
   logic [15:0]                    rd_port;
   logic [tcce_pkg::SLOT_W-1:0]    rd_slot;
   logic [tcce_pkg::SLOT_BITS-1:0] ram_rd_data;
   logic                           wr_en;
   logic                           wr_req;
   tcce_pkg::slot_type             cur, upd, psh_ent;
   logic [3:0]                     cur_st;
   logic [5:0]                     hdr_bytes;
   logic [15:0]                    plen, psh_add;
   logic                           f_fin, f_syn, f_psh, f_ack;
   tcce_pkg::rsp_type              res0, res1;
   logic [1:0]                     res_n;

   function automatic tcce_pkg::rsp_type none_rsp(logic [3:0] st);
      tcce_pkg::rsp_type r;
      r            = '0;
      r.conn_state = st;
      return r;
   endfunction

   function automatic tcce_pkg::rsp_type hdr_rsp(tcce_pkg::slot_type e,
                                                 logic [2:0] words,
                                                 logic [8:0] flags,
                                                 logic dlv,
                                                 logic [5:0] off,
                                                 logic [15:0] len);
      tcce_pkg::rsp_type r;
      r.last_result    = 1'b0;
      r.dest_address   = e.peer_address;
      r.from_port      = e.own_port;
      r.to_port        = e.peer_port;
      r.seq_out        = e.own_seq;
      r.ack_out        = e.peer_seq;
      r.header_words   = words;
      r.flags_out      = flags;
      r.conn_state     = e.state;
      r.deliver        = dlv;
      r.payload_offset = off;
      r.payload_length = len;
      return r;
   endfunction

   // ---------------------------------------------------------------- handshake
   assign pop        = rsp_tvalid && rsp_tready;
   assign adv        = stg_valid_ff && ((out_cnt_ff == 2'd0) || (out_cnt_ff == 2'd1 && pop));
   assign req_tready = !stg_valid_ff || adv;
   assign acc        = req_tvalid && req_tready;
   assign wr_en      = adv && wr_req;

   // ---------------------------------------------------------------- accept side
   assign req_op  = req_tuser;
   assign rd_port = (req_op == tcce_pkg::OP_OPEN) ? port_ff : req_tdata[15:0];
   assign rd_slot = tcce_pkg::slot_of(rd_port);

   always_comb begin
      stg_in.op    = req_op;
      stg_in.port  = rd_port;
      stg_in.slot  = rd_slot;
      stg_in.rip   = req_tdata[47:16];
      stg_in.rport = req_tdata[63:48];
      stg_in.seq   = req_tdata[95:64];
      stg_in.flags = req_tdata[132:128];
      stg_in.doff  = req_tdata[140:137];
      stg_in.slen  = req_tdata[156:141];

      stg_valid_in = stg_valid_ff;
      if (acc) begin
         stg_valid_in = 1'b1;
      end else if (adv) begin
         stg_valid_in = 1'b0;
      end

      port_in = port_ff;
      if (acc && req_op == tcce_pkg::OP_OPEN) begin
         port_in = port_ff + 16'd1;
      end

      // the write-back at the read edge is not seen by the RAM read; hold it
      byp_hit_in  = wr_en && (stg_ff.slot == rd_slot);
      byp_data_in = upd;

      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[stg_ff.slot] = 1'b1;
      end
   end

   tcce_ram #(
      .WIDTH(tcce_pkg::SLOT_BITS),
      .DEPTH(tcce_pkg::CONN_SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(stg_ff.slot),
      .wr_data(upd),
      .rd_en  (acc),
      .rd_addr(rd_slot),
      .rd_data(ram_rd_data)
   );

   // ---------------------------------------------------------------- slot update
   always_comb begin
      cur = byp_hit_ff ? byp_data_ff : tcce_pkg::slot_type'(ram_rd_data);

      cur_st = valid_ff[stg_ff.slot] ? cur.state : tcce_pkg::ST_CLOSED;
      // a slot owned by another port reads as closed
      if (cur_st != tcce_pkg::ST_CLOSED && cur.own_port != stg_ff.port) begin
         cur_st = tcce_pkg::ST_CLOSED;
      end

      f_fin = stg_ff.flags[0];
      f_syn = stg_ff.flags[1];
      f_psh = stg_ff.flags[3];
      f_ack = stg_ff.flags[4];

      hdr_bytes = {stg_ff.doff, 2'b00};
      plen      = (stg_ff.slen > {10'd0, hdr_bytes}) ? stg_ff.slen - {10'd0, hdr_bytes}
                                                    : 16'd0;
      psh_add   = f_psh ? plen : 16'd0;

      psh_ent          = cur;
      psh_ent.peer_seq = cur.peer_seq + {16'd0, plen};

      upd    = cur;
      wr_req = 1'b0;
      res0   = none_rsp(cur_st);
      res1   = none_rsp(tcce_pkg::ST_CLOSED);
      res_n  = 2'd1;

      case (stg_ff.op)
         tcce_pkg::OP_OPEN: begin
            upd.state        = tcce_pkg::ST_SYN_SENT;
            upd.peer_address = stg_ff.rip;
            upd.own_port     = stg_ff.port;
            upd.peer_port    = stg_ff.rport;
            upd.own_seq      = 32'd1;
            upd.peer_seq     = 32'd0;
            wr_req           = 1'b1;
            res0 = hdr_rsp(upd, tcce_pkg::HDR_MSS, tcce_pkg::F_SYN, 1'b0, 6'd0, 16'd0);
         end
         tcce_pkg::OP_SEND: begin
            if (cur_st == tcce_pkg::ST_ESTABLISHED) begin
               res0 = hdr_rsp(cur, tcce_pkg::HDR_PLAIN, tcce_pkg::F_ACK | tcce_pkg::F_PSH,
                              1'b0, 6'd0, stg_ff.slen);
               upd.own_seq = cur.own_seq + {16'd0, stg_ff.slen};
               wr_req      = 1'b1;
            end
         end
         tcce_pkg::OP_RECV: begin
            case (cur_st)
               tcce_pkg::ST_SYN_SENT: begin
                  if (f_syn && f_ack) begin
                     upd.own_seq  = cur.own_seq + 32'd1;
                     upd.peer_seq = stg_ff.seq + 32'd1;
                     upd.state    = tcce_pkg::ST_ESTABLISHED;
                     wr_req       = 1'b1;
                     res0 = hdr_rsp(upd, tcce_pkg::HDR_PLAIN, tcce_pkg::F_ACK,
                                    1'b0, 6'd0, 16'd0);
                  end
               end
               tcce_pkg::ST_CLOSE_WAIT: begin
                  if (f_ack) begin
                     upd.state = tcce_pkg::ST_CLOSED;
                     wr_req    = 1'b1;
                     res0      = none_rsp(tcce_pkg::ST_CLOSED);
                  end
               end
               tcce_pkg::ST_ESTABLISHED: begin
                  if (f_psh) begin
                     upd    = psh_ent;
                     wr_req = 1'b1;
                     res0   = hdr_rsp(psh_ent, tcce_pkg::HDR_PLAIN, tcce_pkg::F_ACK,
                                      1'b1, hdr_bytes, plen);
                  end
                  if (f_fin) begin
                     upd.peer_seq = cur.peer_seq + {16'd0, psh_add} + 32'd1;
                     upd.state    = tcce_pkg::ST_CLOSE_WAIT;
                     wr_req       = 1'b1;
                     if (f_psh) begin
                        res1  = hdr_rsp(upd, tcce_pkg::HDR_PLAIN,
                                        tcce_pkg::F_ACK | tcce_pkg::F_FIN, 1'b0, 6'd0, 16'd0);
                        res_n = 2'd2;
                     end else begin
                        res0  = hdr_rsp(upd, tcce_pkg::HDR_PLAIN,
                                        tcce_pkg::F_ACK | tcce_pkg::F_FIN, 1'b0, 6'd0, 16'd0);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            res0 = none_rsp(tcce_pkg::ST_CLOSED);
         end
      endcase

      if (res_n == 2'd2) begin
         res1.last_result = 1'b1;
      end else begin
         res0.last_result = 1'b1;
      end
   end

   // ---------------------------------------------------------------- result queue
   always_comb begin
      out0_in    = out0_ff;
      out1_in    = out1_ff;
      out_cnt_in = out_cnt_ff;
      if (adv) begin
         out0_in    = res0;
         out1_in    = res1;
         out_cnt_in = res_n;
      end else if (pop) begin
         // advance the second word to the front
         out0_in    = out1_ff;
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   assign rsp_tvalid = (out_cnt_ff != 2'd0);
   assign rsp_tlast  = out0_ff.last_result;
   assign rsp_tdata  = {1'b0,
                        out0_ff.payload_length,
                        out0_ff.payload_offset,
                        out0_ff.deliver,
                        out0_ff.conn_state,
                        out0_ff.flags_out,
                        out0_ff.header_words,
                        out0_ff.ack_out,
                        out0_ff.seq_out,
                        out0_ff.to_port,
                        out0_ff.from_port,
                        out0_ff.dest_address};

   // ---------------------------------------------------------------- flops
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         port_ff      <= tcce_pkg::PORT_START;
         valid_ff     <= '0;
         byp_hit_ff   <= 1'b0;
         out_cnt_ff   <= 2'd0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         port_ff      <= port_in;
         valid_ff     <= valid_in;
         if (acc) begin
            byp_hit_ff <= byp_hit_in;
         end
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         stg_ff      <= stg_in;
         byp_data_ff <= byp_data_in;
      end
      out0_ff <= out0_in;
      out1_ff <= out1_in;
   end

endmodule
